[hw/rtl/spm_pkg.sv]
// Shared types and constants for the sparse polynomial multiply unit.
// Used by spm_ctrl, spm_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package spm_pkg;

	localparam int COEF_W  = 16;
	localparam int EXPON_W = 5;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 36;
	localparam int PEXP_W  = 6;

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic REQ_FIRST  = 1'b0;
	localparam logic REQ_SECOND = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_SCAN,
		ST_SDRAIN,
		ST_ZERO
	} state_t;

	typedef struct packed {
		logic load;       // capture the accepted transaction
		logic store;      // store a first-polynomial term
		logic issue;      // read the next stored term into the multiply pipe
		logic scan_init;  // load the scan pointer with the top slot
		logic scan_step;  // read one slot for emission
		logic emit_zero;  // emit the single zero term
		logic clear;      // drop stored terms and accumulator contents
	} cmd_t;

	typedef struct packed {
		logic count_nz;
		logic issue_last;
		logic pipe_busy;
		logic last_pending;
		logic nz_any;
		logic scan_end;
		logic scan_busy;
	} sts_t;

endpackage

[hw/rtl/spm_ctrl.sv]
// Controller state machine for the sparse polynomial multiply unit.
// Depends on spm_pkg; drives spm_datapath through spm_pkg::cmd_t.
`timescale 1ns / 1ps

module spm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          req_type,
	input  logic          no_term,
	input  logic          last_term,
	input  spm_pkg::sts_t sts,
	output spm_pkg::cmd_t cmd,
	output logic          busy
);

	spm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			spm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (req_type == spm_pkg::REQ_FIRST) begin
						cmd.store = !no_term;
					end else if (!no_term && sts.count_nz) begin
						state_d = spm_pkg::ST_MUL;
					end else if (last_term) begin
						// no products from this term: emit right away
						if (sts.nz_any) begin
							cmd.scan_init = 1'b1;
							state_d       = spm_pkg::ST_SCAN;
						end else begin
							state_d = spm_pkg::ST_ZERO;
						end
					end
				end
			end
			spm_pkg::ST_MUL: begin
				cmd.issue = 1'b1;
				if (sts.issue_last) begin
					state_d = spm_pkg::ST_DRAIN;
				end
			end
			spm_pkg::ST_DRAIN: begin
				// wait for the last accumulator write before looking at the slots
				if (!sts.pipe_busy) begin
					if (!sts.last_pending) begin
						state_d = spm_pkg::ST_IDLE;
					end else if (sts.nz_any) begin
						cmd.scan_init = 1'b1;
						state_d       = spm_pkg::ST_SCAN;
					end else begin
						state_d = spm_pkg::ST_ZERO;
					end
				end
			end
			spm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end) begin
					state_d = spm_pkg::ST_SDRAIN;
				end
			end
			spm_pkg::ST_SDRAIN: begin
				if (!sts.scan_busy) begin
					cmd.clear = 1'b1;
					state_d   = spm_pkg::ST_IDLE;
				end
			end
			spm_pkg::ST_ZERO: begin
				cmd.emit_zero = 1'b1;
				cmd.clear     = 1'b1;
				state_d       = spm_pkg::ST_IDLE;
			end
			default: begin
				state_d = spm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/spm_datapath.sv]
// Datapath of the sparse polynomial multiply unit: term store, multiply and
// accumulate pipe, slot accumulator memory and emission scan. Depends on spm_pkg.
`timescale 1ns / 1ps

module spm_datapath #(
	parameter int MAX_TERMS = 16,
	parameter int MAX_EXP   = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spm_pkg::cmd_t                       cmd,
	output spm_pkg::sts_t                       sts,
	input  logic signed [spm_pkg::COEF_W-1:0]   term_coef,
	input  logic        [spm_pkg::EXPON_W-1:0]  term_expon,
	input  logic                                last_term,
	output logic                                prod_valid,
	output logic        [spm_pkg::ACC_W-1:0]    prod_coef,
	output logic        [spm_pkg::PEXP_W-1:0]   prod_expon,
	output logic                                prod_last
);

	localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);
	localparam int SLOTS  = 2 * MAX_EXP + 1;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ACC_W  = spm_pkg::ACC_W;
	localparam int PROD_W = spm_pkg::PROD_W;

	// captured transaction
	logic signed [spm_pkg::COEF_W-1:0]  coef_q;
	logic        [spm_pkg::EXPON_W-1:0] expon_q;
	logic                               last_q;
	logic        [spm_pkg::EXPON_W-1:0] expon_in;

	// first-polynomial store
	logic signed [spm_pkg::COEF_W-1:0]  first_coef_mem  [MAX_TERMS];
	logic        [spm_pkg::EXPON_W-1:0] first_expon_mem [MAX_TERMS];
	logic        [CNT_W-1:0]            count_q;
	logic        [IDX_W-1:0]            idx_q;

	// multiply and accumulate pipe
	logic                               vld_s1;
	logic signed [spm_pkg::COEF_W-1:0]  fc_s1;
	logic        [spm_pkg::EXPON_W-1:0] fe_s1;
	logic        [spm_pkg::PEXP_W-1:0]  slot_sum;
	logic        [SLOT_W-1:0]           slot_s1;
	logic                               vld_s2;
	logic signed [PROD_W-1:0]           prod_s2;
	logic        [SLOT_W-1:0]           slot_s2;

	// accumulator memory, nonzero map and bypass of the last write
	logic [ACC_W-1:0]  acc_mem [SLOTS];
	logic [ACC_W-1:0]  acc_rd_q;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOTS-1:0]  nz_q;
	logic              fwd_vld_q;
	logic [SLOT_W-1:0] fwd_slot_q;
	logic [ACC_W-1:0]  fwd_data_q;
	logic [ACC_W-1:0]  acc_old;
	logic [ACC_W:0]    acc_sum;
	logic [ACC_W-1:0]  acc_new;

	// emission scan
	logic [SLOT_W-1:0] scan_q;
	logic              scan_s1;
	logic [SLOT_W-1:0] scan_slot_s1;
	logic [SLOTS-1:0]  below_mask;

	logic                       out_vld_q;
	logic [ACC_W-1:0]           out_coef_q;
	logic [spm_pkg::PEXP_W-1:0] out_expon_q;
	logic                       out_last_q;

	assign expon_in = (term_expon > spm_pkg::EXPON_W'(MAX_EXP)) ?
		spm_pkg::EXPON_W'(MAX_EXP) : term_expon;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coef_q  <= term_coef;
			expon_q <= expon_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.load) begin
				last_q <= last_term;
				idx_q  <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.store && count_q < CNT_W'(MAX_TERMS)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// terms beyond the store depth are dropped
	always_ff @(posedge clk) begin
		if (cmd.store && count_q < CNT_W'(MAX_TERMS)) begin
			first_coef_mem[count_q[IDX_W-1:0]]  <= term_coef;
			first_expon_mem[count_q[IDX_W-1:0]] <= expon_in;
		end
		if (cmd.issue) begin
			fc_s1 <= first_coef_mem[idx_q];
			fe_s1 <= first_expon_mem[idx_q];
		end
	end

	assign slot_sum = {1'b0, fe_s1} + {1'b0, expon_q};
	assign slot_s1  = slot_sum[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		prod_s2 <= fc_s1 * coef_q;
		slot_s2 <= slot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// the read for the next product overlaps the write of the current one
	assign acc_old = (fwd_vld_q && fwd_slot_q == slot_s2) ? fwd_data_q :
		(nz_q[slot_s2] ? acc_rd_q : '0);
	assign acc_sum = {acc_old[ACC_W-1], acc_old} +
		{{(ACC_W + 1 - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_comb begin
		case (acc_sum[ACC_W:ACC_W-1])
			2'b01:   acc_new = spm_pkg::ACC_MAX;
			2'b10:   acc_new = spm_pkg::ACC_MIN;
			default: acc_new = acc_sum[ACC_W-1:0];
		endcase
	end

	assign rd_addr = vld_s1 ? slot_s1 : scan_q;

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_mem[slot_s2] <= acc_new;
		end
		acc_rd_q   <= acc_mem[rd_addr];
		fwd_slot_q <= slot_s2;
		fwd_data_q <= acc_new;
	end

	// a slot whose map bit is low reads as zero, so clearing the map clears the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q      <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			fwd_vld_q <= vld_s2;
			if (cmd.clear) begin
				nz_q <= '0;
			end else if (vld_s2) begin
				nz_q[slot_s2] <= (acc_new != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			scan_s1 <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				scan_q <= SLOT_W'(SLOTS - 1);
			end else if (cmd.scan_step) begin
				scan_q <= scan_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_slot_s1 <= scan_q;
	end

	assign below_mask = (SLOTS'(1) << scan_slot_s1) - SLOTS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= (scan_s1 && nz_q[scan_slot_s1]) || cmd.emit_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_zero) begin
			out_coef_q  <= '0;
			out_expon_q <= '0;
			out_last_q  <= 1'b1;
		end else begin
			out_coef_q  <= acc_rd_q;
			out_expon_q <= spm_pkg::PEXP_W'(scan_slot_s1);
			out_last_q  <= ((nz_q & below_mask) == '0);
		end
	end

	assign prod_valid = out_vld_q;
	assign prod_coef  = out_coef_q;
	assign prod_expon = out_expon_q;
	assign prod_last  = out_last_q;

	assign sts.count_nz     = (count_q != '0);
	assign sts.issue_last   = (CNT_W'(idx_q) == count_q - 1'b1);
	assign sts.pipe_busy    = vld_s1 || vld_s2;
	assign sts.last_pending = last_q;
	assign sts.nz_any       = (nz_q != '0);
	assign sts.scan_end     = (scan_q == '0);
	assign sts.scan_busy    = scan_s1;

	a_no_acc_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s2 && scan_s1))
		else $error("accumulator written during emission scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TERMS))
		else $error("stored term count beyond store depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (nz_q == '0) && (count_q == '0))
		else $error("clear left slots or stored terms behind");

	a_zero_term_is_lone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_coef_q == '0) |-> (out_last_q && out_expon_q == '0))
		else $error("zero coefficient emitted as a regular term");

endmodule

[hw/rtl/sparse_polynomial_multiply_unit.sv]
// Top level of the sparse polynomial multiply unit.
// Instantiates spm_ctrl and spm_datapath; depends on spm_pkg.
//
//   channel   handshake              payload
//   input     start / busy           req_type, term_coef, term_expon, no_term, last_term
//   result    prod_valid (strobe)    prod_coef, prod_expon, prod_last
//
// A first-polynomial transaction only stores its term, if it has one. A second-polynomial
// term is accepted, then makes one multiply pass per stored term through the single
// 16x16 multiplier, and then the pipe drains. Emission scans all 2*MAX_EXP+1
// accumulator slots, one memory read a cycle; an all-zero result is emitted as a
// single zero term. Reset clears the accumulator at once through its nonzero map.
// Results are strobes with no back-pressure; busy is high while a second-polynomial
// term is being multiplied or its result emitted, and low in the idle state.
`timescale 1ns / 1ps

module sparse_polynomial_multiply_unit #(
	parameter int MAX_TERMS = 16,
	parameter int MAX_EXP   = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic signed [spm_pkg::COEF_W-1:0]   term_coef,
	input  logic        [spm_pkg::EXPON_W-1:0]  term_expon,
	input  logic                                no_term,
	input  logic                                last_term,
	output logic                                prod_valid,
	output logic        [spm_pkg::ACC_W-1:0]    prod_coef,
	output logic        [spm_pkg::PEXP_W-1:0]   prod_expon,
	output logic                                prod_last
);

	spm_pkg::cmd_t cmd;
	spm_pkg::sts_t sts;

	spm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.no_term   (no_term),
		.last_term (last_term),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	spm_datapath #(
		.MAX_TERMS (MAX_TERMS),
		.MAX_EXP   (MAX_EXP)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.term_coef  (term_coef),
		.term_expon (term_expon),
		.last_term  (last_term),
		.prod_valid (prod_valid),
		.prod_coef  (prod_coef),
		.prod_expon (prod_expon),
		.prod_last  (prod_last)
	);

endmodule
